/* rtl/core/mlbd_pkg.sv */
// Shared constants and types of the multi-line button debouncer.
package mlbd_pkg;

  localparam int NUM_LINES = 8;
  localparam int TIME_BITS = 32;
  localparam int IDX_W = $clog2(NUM_LINES);
  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] DEFAULT_DEBOUNCE_MS = CFG_W'(200);
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // One queued request: which lines settled and the level each settled to.
  typedef struct packed {
    logic [NUM_LINES-1:0] fire_mask;
    logic [NUM_LINES-1:0] levels;
  } evt_t;

endpackage

/* rtl/core/mlbd_if.sv */
// Handshake interfaces for poll samples and debounce events.
interface mlbd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  line_levels;
  logic [7:0]  read_ok_mask;
  logic [31:0] now_ms;

  modport source (output valid, line_levels, read_ok_mask, now_ms, input ready);
  modport sink (input valid, line_levels, read_ok_mask, now_ms, output ready);
endinterface

interface mlbd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] line_index;
  logic       new_level;
  logic       last_event;

  modport source (output valid, line_index, new_level, last_event, input ready);
  modport sink (input valid, line_index, new_level, last_event, output ready);
endinterface

/* rtl/core/mlbd_front.sv */
// Front end: per-line debounce state, updated once per accepted poll sample.
module mlbd_front
  import mlbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 smp_valid,
  input  logic [7:0]           smp_levels,
  input  logic [7:0]           smp_ok,
  input  logic [TIME_BITS-1:0] smp_now,
  input  logic                 accept,
  output logic                 push,
  output evt_t                 push_data
);

  logic [CFG_W-1:0]     debounce_r;
  logic [NUM_LINES-1:0] stable_r, stable_nxt;
  logic [NUM_LINES-1:0] raw_r, raw_nxt;
  logic [NUM_LINES-1:0] armed_r, armed_nxt;
  logic [TIME_BITS-1:0] ctime_r [NUM_LINES];
  logic [TIME_BITS-1:0] ctime_nxt [NUM_LINES];
  logic [NUM_LINES-1:0] fire;
  logic [TIME_BITS-1:0] limit;

  // A zero debounce time falls back to the default.
  assign limit = (debounce_r == '0) ? TIME_BITS'(DEFAULT_DEBOUNCE_MS)
                                    : TIME_BITS'(debounce_r);

  // Each line is evaluated independently against the sample.
  always_comb begin
    logic ok, v, chg, arm_eff;
    logic [TIME_BITS-1:0] diff;
    for (int i = 0; i < NUM_LINES; i++) begin
      ok = (i < 8) ? smp_ok[i % 8] : 1'b0;
      v  = smp_levels[i % 8];
      chg = ok && (v != raw_r[i]);
      raw_nxt[i] = chg ? v : raw_r[i];
      ctime_nxt[i] = chg ? smp_now : ctime_r[i];
      arm_eff = armed_r[i] || chg;
      diff = smp_now - ctime_nxt[i];
      fire[i] = ok && arm_eff && (diff >= limit) && (v != stable_r[i]);
      stable_nxt[i] = fire[i] ? v : stable_r[i];
      armed_nxt[i] = ok ? (arm_eff && !fire[i]) : armed_r[i];
    end
  end

  // Only samples that settle at least one line are queued for the back end.
  assign push = accept && smp_valid && (fire != '0);
  always_comb begin
    push_data.fire_mask = fire;
    for (int i = 0; i < NUM_LINES; i++) begin
      push_data.levels[i] = smp_levels[i % 8];
    end
  end

  // Control state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEFAULT_DEBOUNCE_MS;
      stable_r   <= '1;
      raw_r      <= '1;
      armed_r    <= '0;
    end else begin
      if (cfg_we) begin
        debounce_r <= cfg_wdata;
      end
      if (accept) begin
        stable_r <= stable_nxt;
        raw_r    <= raw_nxt;
        armed_r  <= armed_nxt;
      end
    end
  end

  // Timestamps are only read while a line is armed, so they need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        ctime_r[i] <= ctime_nxt[i];
      end
    end
  end

endmodule

/* rtl/core/mlbd_queue.sv */
// Short queue of event requests between the front and back ends.
module mlbd_queue
  import mlbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_data,
  input  logic pop,
  output evt_t head,
  output logic empty,
  output logic full
);

  evt_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head  = mem_r[rptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a write");
  a_nonzero_entry: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_data.fire_mask != '0) else $error("empty request queued");
`endif

endmodule

/* rtl/core/mlbd_back.sv */
// Back end: drains one queued request as events, lowest line first.
module mlbd_back
  import mlbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  evt_t       head,
  input  logic       empty,
  output logic       pop,
  mlbd_out_if.source out_chan
);

  logic [NUM_LINES-1:0] mask_r;
  logic [NUM_LINES-1:0] lvl_r;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 level_r;
  logic                 last_r;
  logic                 advance;
  logic [IDX_W-1:0]     low_idx;
  logic [NUM_LINES-1:0] mask_rest;

  assign advance = !out_valid_r || out_chan.ready;
  assign pop     = (mask_r == '0) && !empty;

  // Lowest pending line of the current request.
  always_comb begin
    low_idx = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end
  assign mask_rest = mask_r & (mask_r - 1'b1);

  // Request register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mask_r <= head.fire_mask;
      end else if (advance && mask_r != '0) begin
        mask_r <= mask_rest;
      end
      if (advance) begin
        out_valid_r <= (mask_r != '0);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      lvl_r <= head.levels;
    end
    if (advance && mask_r != '0) begin
      idx_r   <= low_idx;
      level_r <= lvl_r[low_idx];
      last_r  <= (mask_rest == '0);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.line_index = 3'(idx_r);
  assign out_chan.new_level  = level_r;
  assign out_chan.last_event = last_r;

endmodule

/* rtl/core/multi_line_button_debouncer.sv */
// A poll sample's events pass through the event queue, the request register and the output register.
// Throughput: a sample is accepted every cycle while the two-entry event queue has room.
// Events drain one per cycle while the receiver is ready; the next queued request
// is loaded only after the last event of the current one has moved into the output register.
// Reset is synchronous, active low: all lines read released, none armed, debounce 200 ms.
// No clearing pass is needed after reset.
module multi_line_button_debouncer
  import mlbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  mlbd_in_if.sink          in_chan,
  mlbd_out_if.source       out_chan
);

  logic accept;
  logic push;
  evt_t push_data;
  evt_t head;
  logic empty;
  logic full;
  logic pop;

  // The front end waits only when the queue is full.
  assign in_chan.ready = !full;
  assign accept = in_chan.valid && !full;

  mlbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .smp_valid  (in_chan.valid),
    .smp_levels (in_chan.line_levels),
    .smp_ok     (in_chan.read_ok_mask),
    .smp_now    (TIME_BITS'(in_chan.now_ms)),
    .accept     (accept),
    .push       (push),
    .push_data  (push_data)
  );

  mlbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  mlbd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

/* tb/multi_line_button_debouncer_tb.sv */
// Self-checking testbench for the multi-line button debouncer: table-driven and random poll requests.
module multi_line_button_debouncer_tb;
  import mlbd_pkg::*;

  // One debounce event as it leaves the block.
  typedef struct packed {
    logic [2:0] line_index;
    logic       new_level;
    logic       last_event;
  } debounce_evt_t;

  // One row of the directed table. When pinned is set, the events are typed in as a
  // mask of firing lines and the levels they settle to.
  typedef struct packed {
    logic        cfg_set;
    logic [15:0] cfg_val;
    logic [7:0]  levels;
    logic [7:0]  ok;
    logic [31:0] now;
    logic        pinned;
    logic [7:0]  fire;
    logic [7:0]  fire_lvl;
  } poll_row_t;

  localparam int ROW_COUNT = 25;
  localparam int RANDOM_POLLS = 100;
  localparam int DRAIN_CYCLES = 8;

  localparam poll_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    // After reset every line reads released, so an all-high sample does nothing.
    '{1'b0, 16'd0, 8'hFF, 8'hFF, 32'd0, 1'b1, 8'h00, 8'h00},
    // Press all lines; they settle exactly when the debounce time has passed.
    '{1'b0, 16'd0, 8'h00, 8'hFF, 32'd0, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'h00, 8'hFF, 32'd199, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'h00, 8'hFF, 32'd200, 1'b1, 8'hFF, 8'h00},
    // Failed reads are skipped, then the halves release at different times.
    '{1'b0, 16'd0, 8'hFF, 8'h00, 32'd300, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'h55, 32'd400, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'hAA, 32'd500, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'hFF, 32'd600, 1'b1, 8'h55, 8'hFF},
    '{1'b0, 16'd0, 8'hFF, 8'hFF, 32'd700, 1'b1, 8'hAA, 8'hFF},
    // A bounce back to the stable level keeps the line armed without an event.
    '{1'b0, 16'd0, 8'hFE, 8'h01, 32'd1000, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'h01, 32'd1050, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'h01, 32'd5000, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFE, 8'h01, 32'd5001, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFE, 8'h01, 32'd5201, 1'b1, 8'h01, 8'hFE},
    // The timestamp wraps between the change and the settle.
    '{1'b0, 16'd0, 8'hFD, 8'h02, 32'hFFFF_FFF0, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFD, 8'h02, 32'h0000_00B8, 1'b1, 8'h02, 8'hFD},
    // A debounce register of zero behaves as the default time.
    '{1'b1, 16'd0, 8'hFF, 8'h02, 32'd1000, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'h02, 32'd1199, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'h02, 32'd1200, 1'b1, 8'h02, 8'hFF},
    // Shortest debounce time.
    '{1'b1, 16'd1, 8'h7F, 8'h80, 32'd2000, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'h7F, 8'h80, 32'd2001, 1'b1, 8'h80, 8'h7F},
    // Longest debounce time.
    '{1'b1, 16'hFFFF, 8'hFF, 8'h80, 32'd3000, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'h80, 32'd68534, 1'b1, 8'h00, 8'h00},
    '{1'b0, 16'd0, 8'hFF, 8'h80, 32'd68535, 1'b1, 8'h80, 8'hFF},
    // Extreme timestamp with every line pressed; checked against the predictor.
    '{1'b0, 16'd0, 8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  mlbd_in_if  in_bus ();
  mlbd_out_if out_bus ();

  multi_line_button_debouncer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  // Predicted per-line state and the debounce setting.
  logic [NUM_LINES-1:0] stable_lvl;
  logic [NUM_LINES-1:0] raw_lvl;
  logic [NUM_LINES-1:0] armed_q;
  logic [TIME_BITS-1:0] change_stamp [NUM_LINES];
  logic [CFG_W-1:0]     debounce_ms_q;

  debounce_evt_t pending_events [$];
  debounce_evt_t exp_ev;

  int err_count = 0;
  int polls_sent = 0;
  int events_seen = 0;
  int settings_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // Free-running clock, period 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one poll sample to the predicted state and return the mask of lines that settle.
  function automatic logic [7:0] settle_poll(input logic [7:0] lv, input logic [7:0] ok,
                                             input logic [31:0] now);
    logic [7:0]  fire;
    logic [31:0] limit;
    logic [31:0] elapsed;
    fire = '0;
    limit = (debounce_ms_q == '0) ? 32'(DEFAULT_DEBOUNCE_MS) : 32'(debounce_ms_q);
    for (int i = 0; i < 8; i++) begin
      if (ok[i]) begin
        if (lv[i] != raw_lvl[i]) begin
          raw_lvl[i] = lv[i];
          change_stamp[i] = now;
          armed_q[i] = 1'b1;
        end
        elapsed = now - change_stamp[i];
        if (armed_q[i] && elapsed >= limit && lv[i] != stable_lvl[i]) begin
          stable_lvl[i] = lv[i];
          armed_q[i] = 1'b0;
          fire[i] = 1'b1;
        end
      end
    end
    return fire;
  endfunction

  // Turn a mask of settling lines into events, lowest line first, flagging the top one.
  function automatic void queue_events(input logic [7:0] fire, input logic [7:0] lv);
    debounce_evt_t ev;
    int top;
    top = -1;
    for (int i = 0; i < 8; i++) begin
      if (fire[i]) top = i;
    end
    for (int i = 0; i < 8; i++) begin
      if (fire[i]) begin
        ev.line_index = 3'(i);
        ev.new_level = lv[i];
        ev.last_event = (i == top);
        pending_events.push_back(ev);
      end
    end
  endfunction

  // Offer one poll request, wait for it to be taken, then record what it should cause.
  task automatic send_poll(input logic [7:0] lv, input logic [7:0] ok, input logic [31:0] now,
                           input logic pinned, input logic [7:0] pin_fire,
                           input logic [7:0] pin_lvl);
    logic [7:0] fire;
    while ($urandom_range(0, 99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.line_levels <= lv;
    in_bus.read_ok_mask <= ok;
    in_bus.now_ms <= now;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    fire = settle_poll(lv, ok, now);
    if (pinned) begin
      queue_events(pin_fire, pin_lvl);
    end else begin
      queue_events(fire, lv);
    end
    polls_sent++;
  endtask

  // Write the debounce register once the block has drained.
  task automatic write_debounce(input logic [CFG_W-1:0] val);
    in_bus.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_ms_q = val;
    settings_seen++;
  endtask

  // Check each event request against the oldest prediction, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: line_index %0d new_level %0d last_event %0d",
               out_bus.line_index, out_bus.new_level, out_bus.last_event);
        err_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_bus.line_index !== exp_ev.line_index) begin
          $error("line_index: expected %0d, got %0d", exp_ev.line_index, out_bus.line_index);
          err_count++;
        end
        if (out_bus.new_level !== exp_ev.new_level) begin
          $error("new_level: expected %0d, got %0d", exp_ev.new_level, out_bus.new_level);
          err_count++;
        end
        if (out_bus.last_event !== exp_ev.last_event) begin
          $error("last_event: expected %0d, got %0d", exp_ev.last_event, out_bus.last_event);
          err_count++;
        end
      end
    end
    out_bus.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Main sequence: reset, directed table, then three random phases.
  initial begin
    logic [7:0]       lv;
    logic [7:0]       ok;
    logic [7:0]       tgt;
    logic [31:0]      stamp;
    logic [31:0]      step_ms;
    logic [CFG_W-1:0] cfg_val;
    int               eff;
    int               r;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.line_levels = '0;
    in_bus.read_ok_mask = '0;
    in_bus.now_ms = '0;
    out_bus.ready = 1'b0;

    stable_lvl = '1;
    raw_lvl = '1;
    armed_q = '0;
    for (int i = 0; i < NUM_LINES; i++) change_stamp[i] = '0;
    debounce_ms_q = DEFAULT_DEBOUNCE_MS;

    send_idle = 38;
    recv_idle = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int n = 0; n < ROW_COUNT; n++) begin
      if (DIRECTED_ROWS[n].cfg_set) write_debounce(DIRECTED_ROWS[n].cfg_val);
      send_poll(DIRECTED_ROWS[n].levels, DIRECTED_ROWS[n].ok, DIRECTED_ROWS[n].now,
                DIRECTED_ROWS[n].pinned, DIRECTED_ROWS[n].fire, DIRECTED_ROWS[n].fire_lvl);
    end

    // Random phases, each with its own idling pattern and debounce setting.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 38;
          recv_idle = 80;
          cfg_val = CFG_W'($urandom_range(1, 40));
        end
        1: begin
          send_idle = 80;
          recv_idle = 38;
          cfg_val = '1;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          cfg_val = CFG_W'(1);
        end
      endcase
      write_debounce(cfg_val);
      eff = (cfg_val == '0) ? int'(DEFAULT_DEBOUNCE_MS) : int'(cfg_val);
      // The first phase starts just short of the timestamp wrap.
      stamp = (p == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4 * eff) : $urandom;
      tgt = 8'($urandom);

      for (int k = 0; k < RANDOM_POLLS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // Noise: any levels, any mask, any timestamp.
          send_poll(8'($urandom), 8'($urandom), $urandom, 1'b0, 8'h00, 8'h00);
        end else begin
          // Press and release patterns with bounce, advancing time around the debounce time.
          if ($urandom_range(0, 3) == 0) tgt = tgt ^ 8'($urandom);
          lv = tgt;
          if ($urandom_range(0, 9) < 3) lv = lv ^ (8'($urandom) & 8'($urandom));
          ok = ($urandom_range(0, 9) < 9) ? 8'hFF : 8'($urandom);
          r = $urandom_range(0, 9);
          if (r < 4) begin
            step_ms = $urandom_range(0, eff / 4);
          end else if (r < 8) begin
            step_ms = $urandom_range(eff - 1, eff + 2);
          end else begin
            step_ms = $urandom_range(0, 3 * eff);
          end
          stamp = stamp + step_ms;
          send_poll(lv, ok, stamp, 1'b0, 8'h00, 8'h00);
        end
      end
    end

    // Drain and settle before the verdict.
    in_bus.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d poll samples and checked %0d debounce events", polls_sent, events_seen);
    $display("across %0d register writes, with and without backpressure.", settings_seen);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
